FILE: src/wav_hdr_pkg.sv
// shared types and constants for the wav header parser
`timescale 1ns / 1ps

package wav_hdr_pkg;

  localparam int unsigned MIN_FILE_LENGTH = 44;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [15:0] PCM_CODE = 16'd1;
  localparam logic [31:0] FMT_BASE_SIZE = 32'd16;

  localparam int unsigned RESULT_W = 216;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_RIFF_ID   = 5'd1,
    PH_RIFF_SIZE = 5'd2,
    PH_WAVE_ID   = 5'd3,
    PH_FMT_ID    = 5'd4,
    PH_FMT_CSIZE = 5'd5,
    PH_FMT_SKIP  = 5'd6,
    PH_FMT_SIZE  = 5'd7,
    PH_AUDIO     = 5'd8,
    PH_CHANNELS  = 5'd9,
    PH_RATE      = 5'd10,
    PH_BYTERATE  = 5'd11,
    PH_ALIGN     = 5'd12,
    PH_BITS      = 5'd13,
    PH_FMT_EXTRA = 5'd14,
    PH_DATA_ID   = 5'd15,
    PH_DATA_CSIZE = 5'd16,
    PH_DATA_SKIP = 5'd17,
    PH_DONE      = 5'd18
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_NOT_RIFF  = 3'd2,
    ST_NOT_WAVE  = 3'd3,
    ST_NO_FMT    = 3'd4,
    ST_NOT_PCM   = 3'd5,
    ST_NO_DATA   = 3'd6
  } status_t;

  // first member lands in the top bits
  typedef struct packed {
    logic [4:0]  pad;
    logic [31:0] data_size;
    logic [15:0] bits_per_sample;
    logic [15:0] block_align;
    logic [31:0] byte_rate;
    logic [31:0] sample_rate;
    logic [15:0] num_channels;
    logic [31:0] fmt_size;
    logic [31:0] riff_size;
    status_t     status;
  } result_t;

endpackage

FILE: src/wav_header_parser_unit.sv
// byte-serial riff/wave pcm header parser with registered result
`timescale 1ns / 1ps
// a result item enters the output register at the clock edge that accepts the byte that ends it
// throughput: one byte item per cycle while s_axis_tready is high; the parser state updates on each accepted byte
// the input stalls only while an unconsumed result sits in the output register
// rst (synchronous) returns the parser to idle, clears file_length and drops the output valid

module wav_header_parser_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [31:0]                         cfg_wdata,      // file_length
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,   // data_byte
  input  logic                                s_axis_tuser,   // first_byte
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // status, riff_size, fmt_size, num_channels, sample_rate, byte_rate,
  // block_align, bits_per_sample, data_size, zero pad
  output logic [wav_hdr_pkg::RESULT_W-1:0]    m_axis_tdata
);

  logic [31:0] file_length;

  wav_hdr_pkg::phase_t phase, phase_next;
  logic [1:0]  byte_in_field, byte_in_field_next;
  logic [31:0] assembly_shift, assembly_shift_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic [31:0] skip_count, skip_count_next;
  logic [31:0] held_riff_size, held_riff_size_next;
  logic [31:0] held_fmt_size, held_fmt_size_next;
  logic [15:0] held_channels, held_channels_next;
  logic [31:0] held_sample_rate, held_sample_rate_next;
  logic [31:0] held_byte_rate, held_byte_rate_next;
  logic [15:0] held_block_align, held_block_align_next;
  logic [15:0] held_bits, held_bits_next;

  wav_hdr_pkg::phase_t eff_phase;
  logic [1:0]  eff_bif;
  logic [31:0] eff_rem;
  logic [31:0] shift_in;
  logic [31:0] rem_minus4;
  logic [31:0] rem_minus2;
  logic [31:0] extra_size;
  logic        field_phase;
  logic        half_field;
  logic        field_done;
  logic        s_fire;
  logic        res_valid;
  wav_hdr_pkg::status_t res_status;
  wav_hdr_pkg::result_t res, m_res;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_length <= '0;
    end else if (cfg_wen) begin
      file_length <= cfg_wdata;
    end
  end

  // restart handling and per-byte field assembly
  always_comb begin
    if (s_axis_tuser) begin
      eff_phase = wav_hdr_pkg::PH_RIFF_ID;
      eff_bif   = '0;
      eff_rem   = file_length;
    end else begin
      eff_phase = phase;
      eff_bif   = byte_in_field;
      eff_rem   = bytes_remaining;
    end
    shift_in   = {s_axis_tdata, assembly_shift[31:8]};
    rem_minus4 = eff_rem - 32'd4;
    rem_minus2 = eff_rem - 32'd2;
    extra_size = held_fmt_size - wav_hdr_pkg::FMT_BASE_SIZE;
    half_field = (eff_phase == wav_hdr_pkg::PH_AUDIO) || (eff_phase == wav_hdr_pkg::PH_CHANNELS)
              || (eff_phase == wav_hdr_pkg::PH_ALIGN) || (eff_phase == wav_hdr_pkg::PH_BITS);
    field_phase = !((eff_phase == wav_hdr_pkg::PH_IDLE) || (eff_phase == wav_hdr_pkg::PH_DONE)
              || (eff_phase == wav_hdr_pkg::PH_FMT_SKIP) || (eff_phase == wav_hdr_pkg::PH_DATA_SKIP)
              || (eff_phase == wav_hdr_pkg::PH_FMT_EXTRA));
    field_done = half_field ? eff_bif[0] : (eff_bif == 2'd3);
  end

  // next state and result
  always_comb begin
    phase_next            = phase;
    byte_in_field_next    = byte_in_field;
    assembly_shift_next   = assembly_shift;
    bytes_remaining_next  = eff_rem;
    skip_count_next       = skip_count;
    held_riff_size_next   = held_riff_size;
    held_fmt_size_next    = held_fmt_size;
    held_channels_next    = held_channels;
    held_sample_rate_next = held_sample_rate;
    held_byte_rate_next   = held_byte_rate;
    held_block_align_next = held_block_align;
    held_bits_next        = held_bits;
    res_valid             = 1'b0;
    res_status            = wav_hdr_pkg::ST_OK;

    if (s_axis_tuser) begin
      held_riff_size_next = file_length - 32'd8;
      phase_next          = wav_hdr_pkg::PH_RIFF_ID;
    end

    if (field_phase) begin
      assembly_shift_next = shift_in;
      byte_in_field_next  = field_done ? 2'd0 : eff_bif + 2'd1;
    end

    if (s_axis_tuser && (file_length < 32'(wav_hdr_pkg::MIN_FILE_LENGTH))) begin
      res_valid  = 1'b1;
      res_status = wav_hdr_pkg::ST_TOO_SHORT;
      phase_next = wav_hdr_pkg::PH_DONE;
      byte_in_field_next  = '0;
      assembly_shift_next = assembly_shift;
    end else begin
      case (eff_phase)
        wav_hdr_pkg::PH_IDLE, wav_hdr_pkg::PH_DONE: begin
        end
        wav_hdr_pkg::PH_RIFF_ID: begin
          if (field_done) begin
            bytes_remaining_next = rem_minus4;
            if (shift_in != wav_hdr_pkg::TAG_RIFF) begin
              res_valid  = 1'b1;
              res_status = wav_hdr_pkg::ST_NOT_RIFF;
              phase_next = wav_hdr_pkg::PH_DONE;
            end else begin
              phase_next = wav_hdr_pkg::PH_RIFF_SIZE;
            end
          end
        end
        wav_hdr_pkg::PH_RIFF_SIZE: begin
          if (field_done) begin
            bytes_remaining_next = rem_minus4;
            phase_next = wav_hdr_pkg::PH_WAVE_ID;
          end
        end
        wav_hdr_pkg::PH_WAVE_ID: begin
          if (field_done) begin
            bytes_remaining_next = rem_minus4;
            if (shift_in != wav_hdr_pkg::TAG_WAVE) begin
              res_valid  = 1'b1;
              res_status = wav_hdr_pkg::ST_NOT_WAVE;
              phase_next = wav_hdr_pkg::PH_DONE;
            end else begin
              phase_next = wav_hdr_pkg::PH_FMT_ID;
            end
          end
        end
        wav_hdr_pkg::PH_FMT_ID: begin
          if (field_done) begin
            bytes_remaining_next = rem_minus4;
            phase_next = (shift_in == wav_hdr_pkg::TAG_FMT) ? wav_hdr_pkg::PH_FMT_SIZE
                                                            : wav_hdr_pkg::PH_FMT_CSIZE;
          end
        end
        wav_hdr_pkg::PH_DATA_ID: begin
          if (field_done) begin
            if (shift_in == wav_hdr_pkg::TAG_DATA) begin
              bytes_remaining_next = eff_rem - 32'd8;
              res_valid  = 1'b1;
              res_status = wav_hdr_pkg::ST_OK;
              phase_next = wav_hdr_pkg::PH_DONE;
            end else begin
              bytes_remaining_next = rem_minus4;
              phase_next = wav_hdr_pkg::PH_DATA_CSIZE;
            end
          end
        end
        wav_hdr_pkg::PH_FMT_CSIZE, wav_hdr_pkg::PH_DATA_CSIZE: begin
          if (field_done) begin
            bytes_remaining_next = rem_minus4;
            if (rem_minus4 < shift_in) begin
              res_valid  = 1'b1;
              res_status = (eff_phase == wav_hdr_pkg::PH_DATA_CSIZE) ? wav_hdr_pkg::ST_NO_DATA
                                                                     : wav_hdr_pkg::ST_NO_FMT;
              phase_next = wav_hdr_pkg::PH_DONE;
            end else begin
              bytes_remaining_next = rem_minus4 - shift_in;
              skip_count_next = shift_in;
              if (eff_phase == wav_hdr_pkg::PH_DATA_CSIZE) begin
                phase_next = (shift_in == '0) ? wav_hdr_pkg::PH_DATA_ID
                                              : wav_hdr_pkg::PH_DATA_SKIP;
              end else begin
                phase_next = (shift_in == '0) ? wav_hdr_pkg::PH_FMT_ID
                                              : wav_hdr_pkg::PH_FMT_SKIP;
              end
            end
          end
        end
        wav_hdr_pkg::PH_FMT_SKIP, wav_hdr_pkg::PH_DATA_SKIP, wav_hdr_pkg::PH_FMT_EXTRA: begin
          skip_count_next = skip_count - 32'd1;
          if (skip_count == 32'd1) begin
            phase_next = (eff_phase == wav_hdr_pkg::PH_FMT_SKIP) ? wav_hdr_pkg::PH_FMT_ID
                                                                 : wav_hdr_pkg::PH_DATA_ID;
          end
        end
        wav_hdr_pkg::PH_FMT_SIZE: begin
          if (field_done) begin
            bytes_remaining_next = rem_minus4;
            held_fmt_size_next = shift_in;
            phase_next = wav_hdr_pkg::PH_AUDIO;
          end
        end
        wav_hdr_pkg::PH_AUDIO: begin
          if (field_done) begin
            bytes_remaining_next = rem_minus2;
            if (shift_in[31:16] != wav_hdr_pkg::PCM_CODE) begin
              res_valid  = 1'b1;
              res_status = wav_hdr_pkg::ST_NOT_PCM;
              phase_next = wav_hdr_pkg::PH_DONE;
            end else begin
              phase_next = wav_hdr_pkg::PH_CHANNELS;
            end
          end
        end
        wav_hdr_pkg::PH_CHANNELS: begin
          if (field_done) begin
            bytes_remaining_next = rem_minus2;
            held_channels_next = shift_in[31:16];
            phase_next = wav_hdr_pkg::PH_RATE;
          end
        end
        wav_hdr_pkg::PH_RATE: begin
          if (field_done) begin
            bytes_remaining_next = rem_minus4;
            held_sample_rate_next = shift_in;
            phase_next = wav_hdr_pkg::PH_BYTERATE;
          end
        end
        wav_hdr_pkg::PH_BYTERATE: begin
          if (field_done) begin
            bytes_remaining_next = rem_minus4;
            held_byte_rate_next = shift_in;
            phase_next = wav_hdr_pkg::PH_ALIGN;
          end
        end
        wav_hdr_pkg::PH_ALIGN: begin
          if (field_done) begin
            bytes_remaining_next = rem_minus2;
            held_block_align_next = shift_in[31:16];
            phase_next = wav_hdr_pkg::PH_BITS;
          end
        end
        wav_hdr_pkg::PH_BITS: begin
          if (field_done) begin
            bytes_remaining_next = rem_minus2;
            held_bits_next = shift_in[31:16];
            if (held_fmt_size > wav_hdr_pkg::FMT_BASE_SIZE) begin
              skip_count_next = extra_size;
              bytes_remaining_next = rem_minus2 - extra_size;
              phase_next = wav_hdr_pkg::PH_FMT_EXTRA;
            end else begin
              phase_next = wav_hdr_pkg::PH_DATA_ID;
            end
          end
        end
        default: begin
          phase_next = wav_hdr_pkg::PH_DONE;
        end
      endcase
    end
  end

  // result item fields
  always_comb begin
    res = '0;
    res.status = res_status;
    if (res_status == wav_hdr_pkg::ST_OK) begin
      res.riff_size       = held_riff_size;
      res.fmt_size        = held_fmt_size;
      res.num_channels    = held_channels;
      res.sample_rate     = held_sample_rate;
      res.byte_rate       = held_byte_rate;
      res.block_align     = held_block_align;
      res.bits_per_sample = held_bits;
      res.data_size       = bytes_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= wav_hdr_pkg::PH_IDLE;
      byte_in_field <= '0;
    end else if (s_fire) begin
      phase         <= phase_next;
      byte_in_field <= byte_in_field_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      assembly_shift   <= assembly_shift_next;
      bytes_remaining  <= bytes_remaining_next;
      skip_count       <= skip_count_next;
      held_riff_size   <= held_riff_size_next;
      held_fmt_size    <= held_fmt_size_next;
      held_channels    <= held_channels_next;
      held_sample_rate <= held_sample_rate_next;
      held_byte_rate   <= held_byte_rate_next;
      held_block_align <= held_block_align_next;
      held_bits        <= held_bits_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_fire && res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && res_valid) begin
      m_res <= res;
    end
  end

  assign m_axis_tdata = m_res;

  a_result_ends_parse: assert property (@(posedge clk) disable iff (rst)
    s_fire && res_valid |=> phase == wav_hdr_pkg::PH_DONE)
    else $error("parser kept running after a result");

  a_no_result_when_idle: assert property (@(posedge clk) disable iff (rst)
    s_fire && !s_axis_tuser
      && (phase == wav_hdr_pkg::PH_IDLE || phase == wav_hdr_pkg::PH_DONE) |-> !res_valid)
    else $error("result from an ignored byte");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == wav_hdr_pkg::PH_FMT_SKIP || phase == wav_hdr_pkg::PH_DATA_SKIP
      || phase == wav_hdr_pkg::PH_FMT_EXTRA) |-> skip_count != '0)
    else $error("skip phase with empty skip count");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_res.status != wav_hdr_pkg::ST_OK
      |-> m_res.riff_size == '0 && m_res.data_size == '0 && m_res.fmt_size == '0)
    else $error("error result carries field data");

  a_field_count_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == wav_hdr_pkg::PH_IDLE || phase == wav_hdr_pkg::PH_DONE
      || phase == wav_hdr_pkg::PH_FMT_SKIP || phase == wav_hdr_pkg::PH_DATA_SKIP
      || phase == wav_hdr_pkg::PH_FMT_EXTRA) |-> byte_in_field == '0)
    else $error("partial field outside a field phase");

endmodule

FILE: tb/wav_header_parser_checker.sv
// checker for the wav header parser: predicts each header result and compares it
`timescale 1ns / 1ps

module wav_header_parser_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [31:0]                      cfg_wdata,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [7:0]                       s_tdata,
  input  logic                             s_tuser,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [wav_hdr_pkg::RESULT_W-1:0] m_tdata,
  output int                               errors,
  output int                               pending,
  output int                               checked
);

  logic [31:0]          file_len;
  wav_hdr_pkg::phase_t  phase;
  logic [1:0]           field_pos;
  logic [31:0]          le_word;
  logic [31:0]          left_in_file;
  logic [31:0]          skip_left;
  logic [31:0]          riff_len;
  logic [31:0]          fmt_len;
  logic [15:0]          chans;
  logic [31:0]          rate;
  logic [31:0]          brate;
  logic [15:0]          align;
  logic [15:0]          bits;
  wav_hdr_pkg::result_t headers_due[$];

  function automatic void clear_parse();
    phase = wav_hdr_pkg::PH_IDLE;
    field_pos = '0;
    le_word = '0;
    left_in_file = '0;
    skip_left = '0;
    riff_len = '0;
    fmt_len = '0;
    chans = '0;
    rate = '0;
    brate = '0;
    align = '0;
    bits = '0;
  endfunction

  // little-endian field assembly, true once n bytes are in
  function automatic bit shift_in(input logic [7:0] b, input int n);
    le_word = {b, le_word[31:8]};
    if (int'(field_pos) + 1 >= n) begin
      field_pos = '0;
      return 1'b1;
    end
    field_pos = field_pos + 2'd1;
    return 1'b0;
  endfunction

  function automatic wav_hdr_pkg::result_t close_parse(input wav_hdr_pkg::status_t st);
    wav_hdr_pkg::result_t r;
    r = '0;
    r.status = st;
    if (st == wav_hdr_pkg::ST_OK) begin
      r.riff_size = riff_len;
      r.fmt_size = fmt_len;
      r.num_channels = chans;
      r.sample_rate = rate;
      r.byte_rate = brate;
      r.block_align = align;
      r.bits_per_sample = bits;
      r.data_size = left_in_file;
    end
    phase = wav_hdr_pkg::PH_DONE;
    return r;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic first,
                                    output wav_hdr_pkg::result_t r);
    logic [31:0] sz;
    r = '0;
    if (first) begin
      clear_parse();
      left_in_file = file_len;
      riff_len = file_len - 32'd8;
      if (file_len < wav_hdr_pkg::MIN_FILE_LENGTH) begin
        r = close_parse(wav_hdr_pkg::ST_TOO_SHORT);
        return 1'b1;
      end
      phase = wav_hdr_pkg::PH_RIFF_ID;
    end else if (phase == wav_hdr_pkg::PH_IDLE || phase >= wav_hdr_pkg::PH_DONE) begin
      return 1'b0;
    end
    case (phase)
      wav_hdr_pkg::PH_RIFF_ID: if (shift_in(b, 4)) begin
        left_in_file -= 32'd4;
        if (le_word != wav_hdr_pkg::TAG_RIFF) begin
          r = close_parse(wav_hdr_pkg::ST_NOT_RIFF);
          return 1'b1;
        end
        phase = wav_hdr_pkg::PH_RIFF_SIZE;
      end
      wav_hdr_pkg::PH_RIFF_SIZE: if (shift_in(b, 4)) begin
        left_in_file -= 32'd4;
        phase = wav_hdr_pkg::PH_WAVE_ID;
      end
      wav_hdr_pkg::PH_WAVE_ID: if (shift_in(b, 4)) begin
        left_in_file -= 32'd4;
        if (le_word != wav_hdr_pkg::TAG_WAVE) begin
          r = close_parse(wav_hdr_pkg::ST_NOT_WAVE);
          return 1'b1;
        end
        phase = wav_hdr_pkg::PH_FMT_ID;
      end
      wav_hdr_pkg::PH_FMT_ID, wav_hdr_pkg::PH_DATA_ID: if (shift_in(b, 4)) begin
        left_in_file -= 32'd4;
        if (phase == wav_hdr_pkg::PH_DATA_ID && le_word == wav_hdr_pkg::TAG_DATA) begin
          left_in_file -= 32'd4;
          r = close_parse(wav_hdr_pkg::ST_OK);
          return 1'b1;
        end
        if (phase == wav_hdr_pkg::PH_FMT_ID && le_word == wav_hdr_pkg::TAG_FMT)
          phase = wav_hdr_pkg::PH_FMT_SIZE;
        else
          phase = (phase == wav_hdr_pkg::PH_DATA_ID) ? wav_hdr_pkg::PH_DATA_CSIZE
                                                     : wav_hdr_pkg::PH_FMT_CSIZE;
      end
      wav_hdr_pkg::PH_FMT_CSIZE, wav_hdr_pkg::PH_DATA_CSIZE: if (shift_in(b, 4)) begin
        left_in_file -= 32'd4;
        sz = le_word;
        if (left_in_file < sz) begin
          r = close_parse((phase == wav_hdr_pkg::PH_DATA_CSIZE) ? wav_hdr_pkg::ST_NO_DATA
                                                                : wav_hdr_pkg::ST_NO_FMT);
          return 1'b1;
        end
        left_in_file -= sz;
        skip_left = sz;
        if (sz == 0)
          phase = (phase == wav_hdr_pkg::PH_DATA_CSIZE) ? wav_hdr_pkg::PH_DATA_ID
                                                        : wav_hdr_pkg::PH_FMT_ID;
        else
          phase = (phase == wav_hdr_pkg::PH_DATA_CSIZE) ? wav_hdr_pkg::PH_DATA_SKIP
                                                        : wav_hdr_pkg::PH_FMT_SKIP;
      end
      wav_hdr_pkg::PH_FMT_SKIP, wav_hdr_pkg::PH_DATA_SKIP, wav_hdr_pkg::PH_FMT_EXTRA: begin
        skip_left -= 32'd1;
        if (skip_left == 0)
          phase = (phase == wav_hdr_pkg::PH_FMT_SKIP) ? wav_hdr_pkg::PH_FMT_ID
                                                      : wav_hdr_pkg::PH_DATA_ID;
      end
      wav_hdr_pkg::PH_FMT_SIZE: if (shift_in(b, 4)) begin
        left_in_file -= 32'd4;
        fmt_len = le_word;
        phase = wav_hdr_pkg::PH_AUDIO;
      end
      wav_hdr_pkg::PH_AUDIO: if (shift_in(b, 2)) begin
        left_in_file -= 32'd2;
        if (le_word[31:16] != wav_hdr_pkg::PCM_CODE) begin
          r = close_parse(wav_hdr_pkg::ST_NOT_PCM);
          return 1'b1;
        end
        phase = wav_hdr_pkg::PH_CHANNELS;
      end
      wav_hdr_pkg::PH_CHANNELS: if (shift_in(b, 2)) begin
        left_in_file -= 32'd2;
        chans = le_word[31:16];
        phase = wav_hdr_pkg::PH_RATE;
      end
      wav_hdr_pkg::PH_RATE: if (shift_in(b, 4)) begin
        left_in_file -= 32'd4;
        rate = le_word;
        phase = wav_hdr_pkg::PH_BYTERATE;
      end
      wav_hdr_pkg::PH_BYTERATE: if (shift_in(b, 4)) begin
        left_in_file -= 32'd4;
        brate = le_word;
        phase = wav_hdr_pkg::PH_ALIGN;
      end
      wav_hdr_pkg::PH_ALIGN: if (shift_in(b, 2)) begin
        left_in_file -= 32'd2;
        align = le_word[31:16];
        phase = wav_hdr_pkg::PH_BITS;
      end
      wav_hdr_pkg::PH_BITS: if (shift_in(b, 2)) begin
        left_in_file -= 32'd2;
        bits = le_word[31:16];
        if (fmt_len > wav_hdr_pkg::FMT_BASE_SIZE) begin
          skip_left = fmt_len - wav_hdr_pkg::FMT_BASE_SIZE;
          left_in_file -= skip_left;
          phase = wav_hdr_pkg::PH_FMT_EXTRA;
        end else begin
          phase = wav_hdr_pkg::PH_DATA_ID;
        end
      end
      default: phase = wav_hdr_pkg::PH_DONE;
    endcase
    return 1'b0;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    wav_hdr_pkg::result_t fresh;
    wav_hdr_pkg::result_t want;
    wav_hdr_pkg::result_t got;
    if (rst) begin
      clear_parse();
      file_len = '0;
      headers_due.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = wav_hdr_pkg::result_t'(m_tdata);
        if (headers_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected header item, expected none, actual %0h", $time, m_tdata);
        end else begin
          want = headers_due.pop_front();
          compare_field("status", want.status, got.status);
          compare_field("riff_size", want.riff_size, got.riff_size);
          compare_field("fmt_size", want.fmt_size, got.fmt_size);
          compare_field("num_channels", want.num_channels, got.num_channels);
          compare_field("sample_rate", want.sample_rate, got.sample_rate);
          compare_field("byte_rate", want.byte_rate, got.byte_rate);
          compare_field("block_align", want.block_align, got.block_align);
          compare_field("bits_per_sample", want.bits_per_sample, got.bits_per_sample);
          compare_field("data_size", want.data_size, got.data_size);
          compare_field("pad", want.pad, got.pad);
          checked++;
        end
      end
      if (cfg_wen) file_len = cfg_wdata;
      if (s_tvalid && s_tready) begin
        if (parse_byte(s_tdata, s_tuser, fresh)) headers_due.push_back(fresh);
      end
    end
    pending = headers_due.size();
  end

endmodule

FILE: tb/wav_header_parser_unit_tb.sv
// testbench top for the wav header parser: byte stimulus, flow control and verdict
`timescale 1ns / 1ps

module wav_header_parser_unit_tb;

  typedef struct {
    logic [31:0] riff_tag;
    logic [31:0] riff_size;
    logic [31:0] wave_tag;
    logic [31:0] fmt_size;
    logic [15:0] audio;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [31:0] brate;
    logic [15:0] align;
    logic [15:0] bits;
    int          pre_chunks;
    int          post_chunks;
    logic [31:0] skip_size;
    int          payload;
  } wav_plan_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_wen = 1'b0;
  logic [31:0]                      cfg_wdata = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [7:0]                       s_axis_tdata = '0;
  logic                             s_axis_tuser = 1'b0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [wav_hdr_pkg::RESULT_W-1:0] m_axis_tdata;

  int          errors;
  int          pending;
  int          checked;
  logic        byte_taken = 1'b0;
  logic        quiet = 1'b0;
  int          hold_requests = 0;
  int          holds_done = 0;
  int          bytes_sent = 0;
  int          files_sent = 0;
  int          writes_done = 0;
  logic [31:0] cur_len = '0;
  logic [7:0]  wav_image[$];

  wav_header_parser_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  wav_header_parser_checker chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_axis_tvalid),
    .s_tready  (s_axis_tready),
    .s_tdata   (s_axis_tdata),
    .s_tuser   (s_axis_tuser),
    .m_tvalid  (m_axis_tvalid),
    .m_tready  (m_axis_tready),
    .m_tdata   (m_axis_tdata),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    byte_taken <= s_axis_tvalid && s_axis_tready;
  end

  initial begin
    #3_000_000;
    $display("wav_header_parser_unit verification failed");
    $finish;
  end

  // result side: random stalls, plus long hold-offs on request
  initial begin
    forever begin
      @(negedge clk);
      if (holds_done < hold_requests) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(negedge clk);
        holds_done++;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 7);
      end
    end
  end

  function automatic logic [15:0] any16();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] any32();
    case ($urandom_range(3))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic void put8(input logic [7:0] v);
    wav_image.push_back(v);
  endfunction

  function automatic void put16(input logic [15:0] v);
    put8(v[7:0]);
    put8(v[15:8]);
  endfunction

  function automatic void put32(input logic [31:0] v);
    put16(v[15:0]);
    put16(v[31:16]);
  endfunction

  // unknown chunk, body cut short when the size is large
  function automatic void put_chunk(input logic [31:0] size);
    logic [31:0] tag;
    tag = $urandom;
    if (tag == wav_hdr_pkg::TAG_FMT || tag == wav_hdr_pkg::TAG_DATA) tag = tag ^ 32'h8000_0000;
    put32(tag);
    put32(size);
    repeat ((size > 12) ? 12 : size) put8(8'($urandom));
  endfunction

  function automatic void build_wav(input wav_plan_t p);
    wav_image.delete();
    put32(p.riff_tag);
    put32(p.riff_size);
    put32(p.wave_tag);
    repeat (p.pre_chunks) put_chunk(p.skip_size);
    put32(wav_hdr_pkg::TAG_FMT);
    put32(p.fmt_size);
    put16(p.audio);
    put16(p.chans);
    put32(p.rate);
    put32(p.brate);
    put16(p.align);
    put16(p.bits);
    if (p.fmt_size > wav_hdr_pkg::FMT_BASE_SIZE && p.fmt_size <= 64) begin
      repeat (p.fmt_size - wav_hdr_pkg::FMT_BASE_SIZE) put8(8'($urandom));
    end
    repeat (p.post_chunks) put_chunk(p.skip_size);
    put32(wav_hdr_pkg::TAG_DATA);
    put32(p.payload);
    repeat (p.payload) put8(8'($urandom));
  endfunction

  function automatic wav_plan_t pcm_plan();
    wav_plan_t p;
    p.riff_tag = wav_hdr_pkg::TAG_RIFF;
    p.riff_size = 32'd36;
    p.wave_tag = wav_hdr_pkg::TAG_WAVE;
    p.fmt_size = wav_hdr_pkg::FMT_BASE_SIZE;
    p.audio = wav_hdr_pkg::PCM_CODE;
    p.chans = 16'd2;
    p.rate = 32'd44100;
    p.brate = 32'd176400;
    p.align = 16'd4;
    p.bits = 16'd16;
    p.pre_chunks = 0;
    p.post_chunks = 0;
    p.skip_size = '0;
    p.payload = 0;
    return p;
  endfunction

  function automatic wav_plan_t random_plan();
    wav_plan_t p;
    p = pcm_plan();
    if ($urandom_range(99) < 4) p.riff_tag = $urandom;
    p.riff_size = $urandom;
    if ($urandom_range(99) < 4) p.wave_tag = $urandom;
    case ($urandom_range(9))
      7, 8: p.fmt_size = $urandom_range(17, 28);
      9: p.fmt_size = $urandom_range(0, 15);
      default: p.fmt_size = wav_hdr_pkg::FMT_BASE_SIZE;
    endcase
    if ($urandom_range(99) < 8) p.audio = 16'($urandom);
    p.chans = any16();
    p.rate = any32();
    p.brate = any32();
    p.align = any16();
    p.bits = any16();
    p.pre_chunks = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 2);
    p.post_chunks = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 2);
    p.skip_size = ($urandom_range(99) < 80) ? $urandom_range(0, 10) : $urandom;
    p.payload = $urandom_range(0, 8);
    return p;
  endfunction

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_byte(input logic [7:0] b, input logic first);
    while (!quiet && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= first;
    do @(negedge clk); while (!byte_taken);
    bytes_sent++;
  endtask

  task automatic send_image(input int count);
    for (int i = 0; i < count; i++) send_byte(wav_image[i], i == 0);
    files_sent++;
  endtask

  // write file_length only once no header result is outstanding
  task automatic set_length(input logic [31:0] v);
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen <= 1'b0;
    cur_len = v;
    writes_done++;
  endtask

  task automatic run_plan(input wav_plan_t p, input logic [31:0] flen);
    build_wav(p);
    if (flen != cur_len) set_length(flen);
    send_image(wav_image.size());
  endtask

  initial begin : stimulus
    wav_plan_t   p;
    logic [31:0] flen;
    int          cut;
    int          pick;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // bytes before any first byte are ignored
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b0);

    // too short, at zero length and one below the minimum
    build_wav(pcm_plan());
    set_length(32'd0);
    send_image(1);
    set_length(wav_hdr_pkg::MIN_FILE_LENGTH - 1);
    send_image(3);

    // minimal file with all-zero fields, then ignored trailing bytes
    p = pcm_plan();
    p.chans = '0;
    p.rate = '0;
    p.brate = '0;
    p.align = '0;
    p.bits = '0;
    run_plan(p, wav_hdr_pkg::MIN_FILE_LENGTH);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);

    // all-ones fields at the largest length
    p = pcm_plan();
    p.chans = '1;
    p.rate = '1;
    p.brate = '1;
    p.align = '1;
    p.bits = '1;
    p.riff_size = '1;
    p.payload = 4;
    run_plan(p, 32'hffff_ffff);

    // bad riff tag, bad wave tag
    p = pcm_plan();
    p.riff_tag = 32'h5846_4952;
    run_plan(p, 32'd44);
    p = pcm_plan();
    p.wave_tag = wav_hdr_pkg::TAG_WAVE ^ 32'h0100_0000;
    run_plan(p, 32'd44);

    // chunk overrun while seeking fmt
    p = pcm_plan();
    p.pre_chunks = 1;
    p.skip_size = '1;
    run_plan(p, 32'd64);

    // not pcm
    p = pcm_plan();
    p.audio = 16'd3;
    run_plan(p, 32'd44);

    // skipped chunks on both sides of fmt, fmt with extra bytes
    p = pcm_plan();
    p.fmt_size = 32'd20;
    p.pre_chunks = 1;
    p.post_chunks = 2;
    p.skip_size = 32'd3;
    p.payload = 5;
    build_wav(p);
    run_plan(p, wav_image.size());

    // fmt size below sixteen
    p = pcm_plan();
    p.fmt_size = 32'd14;
    p.payload = 2;
    run_plan(p, 32'd46);

    // chunk overrun while seeking data
    p = pcm_plan();
    p.post_chunks = 1;
    p.skip_size = 32'd70000;
    run_plan(p, 32'd70);

    // fmt extra filling the rest of the file length, remaining count wraps at the data header
    p = pcm_plan();
    p.fmt_size = 32'd24;
    run_plan(p, 32'd44);

    // restart mid-file, with a length write while mid-parse
    p = pcm_plan();
    p.payload = 2;
    build_wav(p);
    set_length(wav_image.size());
    send_image(20);
    set_length(wav_image.size() + 1);
    send_image(wav_image.size());

    // long result-side hold-off while bytes keep coming
    p = pcm_plan();
    p.payload = 40;
    build_wav(p);
    set_length(wav_image.size());
    hold_requests++;
    send_image(wav_image.size());
    send_image(wav_image.size());

    while (bytes_sent < 1950) begin
      if (files_sent == 20) quiet = 1'b1;
      if (files_sent == 28) quiet = 1'b0;
      pick = $urandom_range(99);
      if (pick < 5) begin
        wav_image.delete();
        repeat ($urandom_range(1, 12)) put8(8'($urandom));
      end else begin
        build_wav(random_plan());
      end
      flen = wav_image.size();
      case ($urandom_range(9))
        0: flen = $urandom;
        1: flen = $urandom_range(0, 50);
        2: flen = flen + $urandom_range(0, 8) - 32'd4;
        default: ;
      endcase
      if (pick >= 5 && $urandom_range(99) < 10) begin
        cut = $urandom_range(0, wav_image.size() - 1);
        wav_image[cut] = wav_image[cut] ^ 8'($urandom_range(1, 255));
      end
      cut = wav_image.size();
      if ($urandom_range(99) < 8) cut = $urandom_range(1, wav_image.size());
      if (flen != cur_len || $urandom_range(99) < 10) set_length(flen);
      send_image(cut);
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("covered %0d byte items in %0d files with %0d length settings",
             bytes_sent, files_sent, writes_done);
    $display("%0d header results compared, all status codes and field extremes driven",
             checked);
    if (errors == 0) begin
      $display("wav_header_parser_unit verification clean");
    end else begin
      $display("wav_header_parser_unit verification failed");
    end
    $finish;
  end

endmodule

FILE: wav_header_parser_unit.f
src/wav_hdr_pkg.sv
src/wav_header_parser_unit.sv
tb/wav_header_parser_checker.sv
tb/wav_header_parser_unit_tb.sv
